// ===== design/fnv1a64_crc32c_fold_hash_defines.svh =====
// assertion macros for the hash block
`ifndef FNV1A64_CRC32C_FOLD_HASH_DEFINES_SVH
`define FNV1A64_CRC32C_FOLD_HASH_DEFINES_SVH

// same-cycle implication
`define FCF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/fcf_pkg.sv =====
package fcf_pkg;

    localparam logic [63:0] FNV_BASIS   = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] FNV_PRIME   = 64'h0000_0100_0000_01B3;
    localparam logic [63:0] GOLDEN_MUL  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last_byte;
    } key_item_t;

    typedef struct packed {
        logic [63:0] hash_value;
        logic        too_long;
    } hash_item_t;

    typedef struct packed {
        logic byte_en;
        logic seed_load;
        logic fold_step;
        logic mul_lo;
        logic mul_hi;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic len_zero;
        logic overflow;
        logic out_free;
    } status_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'b0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // multiply by 2^40 + 0x1b3 as shifts and adds
    function automatic logic [63:0] fnv_step(input logic [63:0] acc, input logic [7:0] b);
        logic [63:0] x;
        x = acc ^ {56'b0, b};
        return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
    endfunction

endpackage

// ===== design/fcf_ctrl.sv =====
module fcf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           key_valid,
    output logic           key_ready,
    input  logic           byte_present,
    input  logic           last_byte,
    input  fcf_pkg::status_t status,
    output fcf_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_BYTES  = 3'd0;
    localparam logic [2:0] S_FOLD   = 3'd1;
    localparam logic [2:0] S_MUL_LO = 3'd2;
    localparam logic [2:0] S_MUL_HI = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       key_accept;

    assign key_ready  = (state_reg == S_BYTES);
    assign key_accept = key_valid && key_ready;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        case (state_reg)
            S_BYTES:
            begin
                cmd.byte_en   = key_accept && byte_present;
                cmd.seed_load = key_accept && last_byte;
                if (key_accept && last_byte)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                if (status.overflow)
                begin
                    state_next = S_DONE;
                end
                else if (status.len_zero)
                begin
                    state_next = S_MUL_LO;
                end
                else
                begin
                    cmd.fold_step = 1'b1;
                end
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_BYTES;
                end
            end
            default:
            begin
                state_next = S_BYTES;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BYTES;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/fcf_dpath.sv =====
module fcf_dpath #(
    parameter int MAX_KEY_BYTES = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         data_byte,
    input  fcf_pkg::cmd_t      cmd,
    output fcf_pkg::status_t   status,
    output logic               hash_valid,
    input  logic               hash_ready,
    output fcf_pkg::hash_item_t hash_item
);

    localparam int LEN_W = $clog2(MAX_KEY_BYTES + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_KEY_BYTES);

    logic [63:0]      fnv_reg;
    logic [31:0]      crc_reg;
    logic [LEN_W-1:0] len_reg;
    logic             ovf_reg;
    logic [31:0]      seed_reg;
    logic [63:0]      prod_lo_reg;
    logic [31:0]      prod_hi_reg;
    logic [63:0]      hash_reg;
    logic             too_long_reg;
    logic             out_valid_reg;

    logic             byte_take;
    logic [63:0]      fnv_upd;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      prod;
    logic [63:0]      mix;

    assign byte_take = cmd.byte_en && !ovf_reg && (len_reg < LEN_MAX);
    assign fnv_upd   = byte_take ? fcf_pkg::fnv_step(fnv_reg, data_byte) : fnv_reg;

    // shared 32x32 multiplier, low then high half of the constant
    assign mul_a = seed_reg ^ crc_reg;
    assign mul_b = cmd.mul_hi ? fcf_pkg::GOLDEN_MUL[63:32] : fcf_pkg::GOLDEN_MUL[31:0];
    assign prod  = 64'(mul_a) * 64'(mul_b);
    assign mix   = prod_lo_reg + {prod_hi_reg, 32'b0};

    assign status.len_zero = (len_reg == '0);
    assign status.overflow = ovf_reg;
    assign status.out_free = !out_valid_reg || hash_ready;

    assign hash_valid           = out_valid_reg;
    assign hash_item.hash_value = hash_reg;
    assign hash_item.too_long   = too_long_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fnv_reg       <= fcf_pkg::FNV_BASIS;
            crc_reg       <= '0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                fnv_reg <= fcf_pkg::FNV_BASIS;
                crc_reg <= '0;
                len_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else if (cmd.fold_step)
            begin
                len_reg <= len_reg - 1'b1;
            end
            else if (byte_take)
            begin
                fnv_reg <= fnv_upd;
                crc_reg <= fcf_pkg::crc_byte(crc_reg, data_byte);
                len_reg <= len_reg + 1'b1;
            end
            else if (cmd.byte_en)
            begin
                ovf_reg <= 1'b1;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (hash_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.seed_load)
        begin
            seed_reg <= fnv_upd[31:0];
        end
        else if (cmd.fold_step)
        begin
            seed_reg <= fcf_pkg::crc_byte(seed_reg, 8'h00);
        end
        if (cmd.mul_lo)
        begin
            prod_lo_reg <= prod;
        end
        if (cmd.mul_hi)
        begin
            prod_hi_reg <= prod[31:0];
        end
        if (cmd.out_load)
        begin
            hash_reg     <= ovf_reg ? 64'd0 : (fnv_reg ^ mix);
            too_long_reg <= ovf_reg;
        end
    end

endmodule

// ===== design/fnv1a64_crc32c_fold_hash.sv =====
// channel   dir  handshake              payload
// key       in   key_valid/key_ready    key_item  (fcf_pkg::key_item_t)
// hash      out  hash_valid/hash_ready  hash_item (fcf_pkg::hash_item_t)
//
// a key item is taken on each key_valid/key_ready handshake; an item with last_byte then holds the input off
// for L stored bytes through L zero-byte crc steps, a step to see the count at zero,
// two steps on the shared 32x32 multiplier and the load of the output register, which waits for it to be free
// an overlong key skips the fold and the multiply and goes straight to the output load
// rst_n clears the controller, the key state and the output valid at once
// a result waits in the output register while the next key streams; the next load waits for it
module fnv1a64_crc32c_fold_hash #(
    parameter int MAX_KEY_BYTES = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                key_valid,
    output logic                key_ready,
    input  fcf_pkg::key_item_t  key_item,
    output logic                hash_valid,
    input  logic                hash_ready,
    output fcf_pkg::hash_item_t hash_item
);

    `include "fnv1a64_crc32c_fold_hash_defines.svh"

    fcf_pkg::cmd_t    cmd;
    fcf_pkg::status_t status;

    fcf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_valid    (key_valid),
        .key_ready    (key_ready),
        .byte_present (key_item.byte_present),
        .last_byte    (key_item.last_byte),
        .status       (status),
        .cmd          (cmd)
    );

    fcf_dpath #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (key_item.data_byte),
        .cmd        (cmd),
        .status     (status),
        .hash_valid (hash_valid),
        .hash_ready (hash_ready),
        .hash_item  (hash_item)
    );

    `FCF_ASSERT_NOW(a_too_long_zero, clk, rst_n, hash_valid && hash_item.too_long, hash_item.hash_value == 64'd0, "too_long result with nonzero hash")
    `FCF_ASSERT_NEXT(a_end_stops_input, clk, rst_n, key_valid && key_ready && key_item.last_byte, !key_ready, "input still taken after key end")
    `FCF_ASSERT_NOW(a_fold_nonempty, clk, rst_n, cmd.fold_step, !status.len_zero && !status.overflow, "fold step with no bytes left")

endmodule
